@@ hdl/fhm_pkg.sv @@
// ----------------------------------------------------------------------------
// fhm_pkg
// Shared types and codes for the mutex table with FIFO wait queues.
// ----------------------------------------------------------------------------
`default_nettype none

package fhm_pkg;

  localparam int NUM_LOCKS_DEF   = 16;
  localparam int NUM_THREADS_DEF = 64;

  localparam int KIND_W   = 1;
  localparam int LOCKID_W = 4;
  localparam int THID_W   = 6;
  localparam int STATUS_W = 3;

  // request kinds
  localparam logic [KIND_W-1:0] KIND_LOCK   = 1'b0;
  localparam logic [KIND_W-1:0] KIND_UNLOCK = 1'b1;

  // result codes
  localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] ST_QUEUED     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DEADLOCK   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_OWNER  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOT_LOCKED = 3'd4;
  localparam logic [STATUS_W-1:0] ST_WAITING    = 3'd5;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [LOCKID_W-1:0] lock_id;
    logic [THID_W-1:0]   thread_id;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                woken_valid;
    logic [THID_W-1:0]   woken_thread;
  } rsp_t;

endpackage

`default_nettype wire

@@ hdl/fifo_handoff_mutex_table_core.sv @@
// ----------------------------------------------------------------------------
// fifo_handoff_mutex_table_core
// Table of mutexes with per-lock FIFO wait queues kept in synchronous RAMs.
// ----------------------------------------------------------------------------
// Sequence: an accepted request reads its lock-table row in S_READ; an unlock
//   that hands off to a waiter adds S_NEXT (one extra RAM read of the waiter's
//   next pointer). A new transaction is taken only after the lock-table
//   read-modify-write ends, and start is taken again while done is high.
// Reset: synchronous; afterwards busy stays high while the waiting-flag RAM
//   is swept to zero. The receiver cannot stall results.
`default_nettype none

module fifo_handoff_mutex_table_core
  import fhm_pkg::*;
#(
  parameter int NUM_LOCKS   = NUM_LOCKS_DEF,
  parameter int NUM_THREADS = NUM_THREADS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire req_t req,
  output logic      busy,
  output logic      done,
  output rsp_t      rsp
);

  localparam int LW = $clog2(NUM_LOCKS);
  localparam int TW = $clog2(NUM_THREADS);

  // sequencer codes
  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_READ  = 2'd2;
  localparam logic [1:0] S_NEXT  = 2'd3;

  // One lock-table row: busy mark, owner and the wait queue's head/tail.
  typedef struct packed {
    logic          busy;
    logic [TW-1:0] owner;
    logic [TW-1:0] head;
    logic [TW-1:0] tail;
    logic          nonempty;
  } entry_t;

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  logic [1:0]          state, state_next;
  logic [TW-1:0]       clr_idx;
  logic [KIND_W-1:0]   req_kind;
  logic [LW-1:0]       req_lk;
  logic [TW-1:0]       req_th;
  entry_t              ent_q;
  logic [NUM_LOCKS-1:0] lock_valid;

  // RAMs: lock table, waiting flag per thread, next pointer per thread.
  // The lock table has a valid bit per row; an unwritten row reads as free.
  // The waiting flags get a zeroing sweep after reset. The next pointers are
  // only read on queues of two or more, so they are never cleared.
  entry_t        lock_mem [NUM_LOCKS];
  logic          wait_mem [NUM_THREADS];
  logic [TW-1:0] next_mem [NUM_THREADS];

  entry_t        lock_rd;
  logic          lock_rd_vld;
  logic          wait_rd;
  logic [TW-1:0] next_rd;

  // --------------------------------------------------------------------------
  // Index reduction: lock_id mod NUM_LOCKS, thread_id mod NUM_THREADS, done
  // by conditional subtraction of shifted multiples (few narrow steps).
  // --------------------------------------------------------------------------
  logic [16:0]   lk_rem, th_rem;
  logic [LW-1:0] lk_in;
  logic [TW-1:0] th_in;

  always_comb begin
    lk_rem = 17'(req.lock_id);
    for (int k = 3; k >= 0; k--) begin
      if (lk_rem >= (17'(NUM_LOCKS) << k)) begin
        lk_rem = lk_rem - (17'(NUM_LOCKS) << k);
      end
    end
    th_rem = 17'(req.thread_id);
    for (int k = 5; k >= 0; k--) begin
      if (th_rem >= (17'(NUM_THREADS) << k)) begin
        th_rem = th_rem - (17'(NUM_THREADS) << k);
      end
    end
  end

  assign lk_in = LW'(lk_rem);
  assign th_in = TW'(th_rem);

  logic accept;
  assign accept = start && (state == S_IDLE);
  assign busy   = (state != S_IDLE);

  // --------------------------------------------------------------------------
  // Decision logic
  // --------------------------------------------------------------------------
  entry_t        ent_cur;
  entry_t        lock_wdata;
  logic          lock_we;
  logic          wait_we;
  logic [TW-1:0] wait_waddr;
  logic          wait_wdata;
  logic          next_we;
  logic          fin;
  rsp_t          rsp_next;

  assign ent_cur = lock_rd_vld ? lock_rd : '0;

  always_comb begin
    state_next = state;
    lock_we    = 1'b0;
    lock_wdata = ent_cur;
    wait_we    = 1'b0;
    wait_waddr = req_th;
    wait_wdata = 1'b0;
    next_we    = 1'b0;
    fin        = 1'b0;
    rsp_next   = '0;
    case (state)
      S_CLEAR: begin
        wait_we    = 1'b1;
        wait_waddr = clr_idx;
        wait_wdata = 1'b0;
        if (clr_idx == TW'(NUM_THREADS - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        fin        = 1'b1;
        state_next = S_IDLE;
        if (wait_rd) begin
          rsp_next.status = ST_WAITING;
        end else if (req_kind == KIND_LOCK) begin
          if (ent_cur.busy && (ent_cur.owner == req_th)) begin
            rsp_next.status = ST_DEADLOCK;
          end else if (ent_cur.busy) begin
            // append to the tail of the wait queue
            if (ent_cur.nonempty) begin
              next_we = 1'b1;
            end else begin
              lock_wdata.head     = req_th;
              lock_wdata.nonempty = 1'b1;
            end
            lock_wdata.tail = req_th;
            lock_we         = 1'b1;
            wait_we         = 1'b1;
            wait_wdata      = 1'b1;
            rsp_next.status = ST_QUEUED;
          end else begin
            lock_wdata.busy  = 1'b1;
            lock_wdata.owner = req_th;
            lock_we          = 1'b1;
            rsp_next.status  = ST_OK;
          end
        end else begin
          if (!ent_cur.busy) begin
            rsp_next.status = ST_NOT_LOCKED;
          end else if (ent_cur.owner != req_th) begin
            rsp_next.status = ST_NOT_OWNER;
          end else if (ent_cur.nonempty) begin
            // handoff: head waiter stops waiting; its next pointer is read now
            fin        = 1'b0;
            state_next = S_NEXT;
            wait_we    = 1'b1;
            wait_waddr = ent_cur.head;
            wait_wdata = 1'b0;
          end else begin
            lock_wdata.busy  = 1'b0;
            lock_wdata.owner = '0;
            lock_we          = 1'b1;
            rsp_next.status  = ST_OK;
          end
        end
      end
      S_NEXT: begin
        lock_wdata       = ent_q;
        lock_wdata.owner = ent_q.head;
        if (ent_q.head == ent_q.tail) begin
          lock_wdata.nonempty = 1'b0;
        end else begin
          lock_wdata.head = next_rd;
        end
        lock_we               = 1'b1;
        fin                   = 1'b1;
        state_next            = S_IDLE;
        rsp_next.status       = ST_OK;
        rsp_next.woken_valid  = 1'b1;
        rsp_next.woken_thread = THID_W'(ent_q.head);
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_idx    <= '0;
      done       <= 1'b0;
      lock_valid <= '0;
    end else begin
      state <= state_next;
      done  <= fin;
      if (state == S_CLEAR) begin
        clr_idx <= clr_idx + 1'b1;
      end
      if (lock_we) begin
        lock_valid[req_lk] <= 1'b1;
      end
    end
  end

  // Transaction payload and result; no reset needed.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_kind <= req.kind;
      req_lk   <= lk_in;
      req_th   <= th_in;
    end
    if (state == S_READ) begin
      ent_q <= ent_cur;
    end
    if (fin) begin
      rsp <= rsp_next;
    end
  end

  // --------------------------------------------------------------------------
  // RAMs with registered reads. Writes land only in S_CLEAR, S_READ and S_NEXT
  // and the next read is issued in S_IDLE, so no same-entry overlap occurs.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (lock_we) begin
      lock_mem[req_lk] <= lock_wdata;
    end
    lock_rd     <= lock_mem[lk_in];
    lock_rd_vld <= lock_valid[lk_in];
  end

  always_ff @(posedge clk) begin
    if (wait_we) begin
      wait_mem[wait_waddr] <= wait_wdata;
    end
    wait_rd <= wait_mem[th_in];
  end

  always_ff @(posedge clk) begin
    if (next_we) begin
      next_mem[ent_cur.tail] <= req_th;
    end
    next_rd <= next_mem[ent_cur.head];
  end

endmodule

`default_nettype wire

@@ hdl/fhm_checker.sv @@
// ----------------------------------------------------------------------------
// fhm_checker
// Port-level checks on the mutex table, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module fhm_checker
  import fhm_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic busy,
  input wire logic done,
  input wire rsp_t rsp
);

  // an accepted transaction keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  // one result per transaction, never in two adjacent cycles
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for two cycles");

  // a handoff is always a successful release
  a_woken_ok: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.woken_valid) |-> (rsp.status == ST_OK))
    else $error("woken thread reported with a failure status");

  // no woken thread without a handoff
  a_woken_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !rsp.woken_valid) |-> (rsp.woken_thread == '0))
    else $error("woken thread set without handoff");

  // status code in range
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (rsp.status <= ST_WAITING))
    else $error("status code out of range");

endmodule

bind fifo_handoff_mutex_table_core fhm_checker u_fhm_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done),
  .rsp   (rsp)
);

`default_nettype wire
